[rtl/urlpd_pkg.sv]
// ----------------------------------------------------------------------------
// urlpd_pkg
// Types, phase codes, configuration indexes, character codes and hex helper for the percent decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

	// input transaction payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_t;

	// result transaction payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       string_done;
	} out_t;

	// decoded hex digit
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// escape phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MASK_BYTES  = 2'd1;
	localparam int unsigned CFG_DATA_W = 64;

	// character codes
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	function automatic hex_t hex_digit(input logic [7:0] ch);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (ch inside {[8'h30:8'h39]}) begin
			r.val = 4'(ch - 8'h30);
		end else if (ch inside {[8'h61:8'h66]}) begin
			r.val = 4'(ch - 8'h57);
		end else if (ch inside {[8'h41:8'h46]}) begin
			r.val = 4'(ch - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/url_percent_decode_masked_core.sv]
// ----------------------------------------------------------------------------
// url_percent_decode_masked_core
// Streaming percent decoder with an optional cyclic xor key.
// ----------------------------------------------------------------------------
// One encoded character enters per transaction and the block sustains one
// transaction per clock while the result channel is not stalled. A character
// is taken into an input register, decoded in a single pass against the
// escape and key state, and its result (if any) is written to a result
// register and presented from there. Characters that give no result (an
// opening '%' and the first escape character) only update state and never
// occupy the result register. The rate is set by the state update from the
// input register to the escape and key registers; the result register lets a
// new character enter while a finished result waits downstream. An end item
// always gives one result with string_done set, a masked '%' when an escape
// was left open. The user writes configuration (key length, key bytes) through
// the cfg port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module url_percent_decode_masked_core #(
	parameter int unsigned MASK_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  urlpd_pkg::in_t                      in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output urlpd_pkg::out_t                     out_data,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [urlpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [urlpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [3:0] MaxLen = 4'(MASK_BYTES);

	// configuration registers
	logic [3:0]                  mask_length_q;
	logic [MASK_BYTES-1:0][7:0]  key_q;

	// input stage
	logic            valid_s1;
	urlpd_pkg::in_t  in_s1;

	// decoder state
	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic [7:0] last_q;
	logic [2:0] key_pos_q;

	// result register
	logic            out_valid_q;
	urlpd_pkg::out_t out_q;

	// decode outputs
	logic            gives_result;
	urlpd_pkg::out_t res;
	logic [1:0]      phase_n;
	logic [7:0]      held_n;
	logic [7:0]      last_n;
	logic [2:0]      key_pos_n;

	// key path
	logic [3:0] len_eff;
	logic [3:0] pos_use;
	logic [3:0] pos_inc;
	logic [2:0] pos_adv;
	logic [7:0] key_byte;
	logic [7:0] plain;
	logic       use_key;

	urlpd_pkg::hex_t hex_hi;
	urlpd_pkg::hex_t hex_lo;

	logic slot_free;
	logic advance_s1;

	// handshake: the stage moves on unless it holds a result with nowhere to go
	assign slot_free  = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!gives_result || slot_free);
	assign in_ready   = !valid_s1 || advance_s1;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_length_q <= 4'd0;
			key_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				urlpd_pkg::CFG_MASK_LENGTH: mask_length_q <= cfg_data[3:0];
				urlpd_pkg::CFG_MASK_BYTES:  key_q <= cfg_data[MASK_BYTES*8-1:0];
				default: ;
			endcase
		end
	end

	// key length saturates, stale position falls back to byte 0
	always_comb begin
		len_eff  = (mask_length_q > MaxLen) ? MaxLen : mask_length_q;
		pos_use  = ({1'b0, key_pos_q} >= len_eff) ? 4'd0 : {1'b0, key_pos_q};
		pos_inc  = pos_use + 4'd1;
		pos_adv  = (pos_inc >= len_eff) ? 3'd0 : pos_inc[2:0];
		key_byte = 8'd0;
		for (int i = 0; i < MASK_BYTES; i++) begin
			if (pos_use == 4'(i)) begin
				key_byte = key_q[i];
			end
		end
	end

	assign hex_hi = urlpd_pkg::hex_digit(held_q);
	assign hex_lo = urlpd_pkg::hex_digit(in_s1.data_byte);

	// single pass decode of the character in the input stage
	always_comb begin
		gives_result = 1'b0;
		use_key      = 1'b0;
		plain        = 8'd0;
		res          = '0;
		phase_n      = phase_q;
		held_n       = held_q;
		last_n       = last_q;
		key_pos_n    = key_pos_q;

		if (in_s1.end_of_string) begin
			// end item: always one result, a masked '%' if an escape is open
			gives_result    = 1'b1;
			res.string_done = 1'b1;
			if (phase_q != urlpd_pkg::PH_IDLE) begin
				use_key      = 1'b1;
				plain        = urlpd_pkg::CH_PERCENT;
				res.has_byte = 1'b1;
			end
		end else begin
			case (phase_q)
				urlpd_pkg::PH_FIRST: begin
					held_n  = in_s1.data_byte;
					phase_n = urlpd_pkg::PH_SECOND;
				end
				urlpd_pkg::PH_SECOND: begin
					// non-hex first char keeps the previous escape value
					if (hex_hi.ok) begin
						last_n = hex_lo.ok ? {hex_hi.val, hex_lo.val} : {4'd0, hex_hi.val};
					end
					plain        = last_n;
					phase_n      = urlpd_pkg::PH_IDLE;
					held_n       = 8'd0;
					gives_result = 1'b1;
					use_key      = 1'b1;
					res.has_byte = 1'b1;
				end
				default: begin
					if (in_s1.data_byte == urlpd_pkg::CH_PERCENT) begin
						phase_n = urlpd_pkg::PH_FIRST;
					end else begin
						plain = (in_s1.data_byte == urlpd_pkg::CH_PLUS) ?
							urlpd_pkg::CH_SPACE : in_s1.data_byte;
						gives_result = 1'b1;
						use_key      = 1'b1;
						res.has_byte = 1'b1;
					end
				end
			endcase
		end

		// masking, with the key position moving only when a key is in use
		if (use_key) begin
			if (len_eff != 4'd0) begin
				res.out_byte = plain ^ key_byte;
				key_pos_n    = pos_adv;
			end else begin
				res.out_byte = plain;
			end
		end

		// an end item returns all state to reset
		if (in_s1.end_of_string) begin
			phase_n   = urlpd_pkg::PH_IDLE;
			held_n    = 8'd0;
			last_n    = 8'd0;
			key_pos_n = 3'd0;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= urlpd_pkg::PH_IDLE;
			held_q    <= 8'd0;
			last_q    <= 8'd0;
			key_pos_q <= 3'd0;
		end else if (advance_s1) begin
			phase_q   <= phase_n;
			held_q    <= held_n;
			last_q    <= last_n;
			key_pos_q <= key_pos_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= advance_s1 && gives_result;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && advance_s1 && gives_result) begin
			out_q <= res;
		end
	end

`ifndef ASSERT_OFF
	// key position always lands inside the key
	a_key_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, key_pos_q} < MaxLen)
		else $error("key position out of range");

	// an end item leaves the decoder in its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && in_s1.end_of_string |=>
		phase_q == urlpd_pkg::PH_IDLE && key_pos_q == 3'd0 && last_q == 8'd0)
		else $error("state not cleared after end of string");

	// a result without a byte can only be the closing result
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_byte |-> out_q.string_done && out_q.out_byte == 8'd0)
		else $error("empty result that does not close the string");

	// a stalled input stage keeps its character
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(in_s1))
		else $error("input stage lost a stalled character");

	// a result is only produced when the result register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule
